### rtl/core/tas_pkg.sv
// Shared types and codes of the timed action sequencer.
`default_nettype none
package tas_pkg;
   typedef struct packed {
      logic [7:0]         dev;
      logic [7:0]         ident;
      logic [7:0]         op;
      logic signed [15:0] val;
      logic signed [15:0] tm;
   } entry_type;

   typedef struct packed {
      logic [2:0] kind;
      entry_type  e;
   } result_type;

   localparam logic [2:0] REQ_ADD   = 3'd0;
   localparam logic [2:0] REQ_CLEAR = 3'd1;
   localparam logic [2:0] REQ_START = 3'd2;
   localparam logic [2:0] REQ_ABORT = 3'd3;
   localparam logic [2:0] REQ_TICK  = 3'd4;

   localparam logic [2:0] KIND_ADDED   = 3'd0;
   localparam logic [2:0] KIND_FULL    = 3'd1;
   localparam logic [2:0] KIND_CLEARED = 3'd2;
   localparam logic [2:0] KIND_EMPTY   = 3'd3;
   localparam logic [2:0] KIND_FIRE    = 3'd4;
   localparam logic [2:0] KIND_FINISH  = 3'd5;
   localparam logic [2:0] KIND_DONE    = 3'd6;
   localparam logic [2:0] KIND_ABORTED = 3'd7;

   localparam logic signed [15:0] ELAPSED_MAX = 16'sd32767;
endpackage
`default_nettype wire

### rtl/core/tas_cell.sv
// One table slot of the sorted insertion chain.
`default_nettype none
module tas_cell
   import tas_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      write_en,
   input  wire logic      valid,
   input  wire logic      at_count,
   input  wire entry_type new_entry,
   input  wire entry_type prev_entry,
   input  wire logic      prev_ins,
   output entry_type      entry,
   output logic           ins
);
   entry_type entry_ff;

   // A slot takes part in the shift when the new item sorts before it,
   // or when it is the first free slot.
   assign ins   = valid ? (new_entry.tm < entry_ff.tm) : at_count;
   assign entry = entry_ff;

   always_ff @(posedge clock) begin
      if (write_en && ins) begin
         entry_ff <= prev_ins ? prev_entry : new_entry;
      end
   end
endmodule
`default_nettype wire

### rtl/core/timed_action_sequencer_core.sv
// Top level of the timed action sequencer: command handling and result sequencing.
`default_nettype none
//  Channel | Direction | Ports
//  request | in        | req_valid, req_ready, req_type .. req_close_when_done
//  result  | out       | rsp_valid, rsp_ready, rsp_result_kind .. rsp_last
//
// One request is taken at a time; req_ready is high only while the sequencer is idle.
// A start, tick or abort walks the entries through the single table read port,
// one per cycle while the result channel is not stalled.
// Reset is synchronous and clears the count, flags, elapsed time and handshake state;
// table slots are undefined until written. A stalled result channel freezes the walk.
module timed_action_sequencer_core
   import tas_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_type,
   input  wire logic [7:0]        req_device_code,
   input  wire logic [7:0]        req_item_id,
   input  wire logic [7:0]        req_operation_code,
   input  wire logic signed [15:0] req_action_value,
   input  wire logic signed [15:0] req_fire_time,
   input  wire logic              req_close_when_done,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [2:0]             rsp_result_kind,
   output logic [7:0]             rsp_out_device,
   output logic [7:0]             rsp_out_item_id,
   output logic [7:0]             rsp_out_operation,
   output logic signed [15:0]     rsp_out_value,
   output logic signed [15:0]     rsp_out_time,
   output logic                   rsp_last
);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_FIRE, ST_SWEEP, ST_FLUSH} state_type;

   state_type    state_ff;
   logic [CW-1:0] count_ff, next_ff, idx_ff;
   logic          running_ff, close_ff;
   logic signed [15:0] elapsed_ff;
   result_type    pend_ff, rsp_ff;
   logic          pend_valid_ff, rsp_valid_ff, rsp_last_ff;

   entry_type cell_entry [TABLE_DEPTH];
   logic      cell_ins   [TABLE_DEPTH];
   entry_type new_entry, rd_entry;
   logic      ins_en, adv;
   logic      fire_end, fire_due, rsp_load;
   logic [CW-1:0] rd_sel;

   assign new_entry = '{dev: req_device_code, ident: req_item_id, op: req_operation_code,
                        val: req_action_value, tm: req_fire_time};
   assign req_ready = (state_ff == ST_IDLE);
   assign ins_en = req_valid && req_ready && (req_type == REQ_ADD) && (count_ff < DEPTH_C);
   // The output register can take a new item when it is empty or being drained.
   assign adv = !rsp_valid_ff || rsp_ready;

   // The insertion chain: each slot either holds, takes its left neighbor,
   // or takes the new item.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      tas_cell u_cell (
         .clock      (clock),
         .write_en   (ins_en),
         .valid      (CW'(i) < count_ff),
         .at_count   (CW'(i) == count_ff),
         .new_entry  (new_entry),
         .prev_entry ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
         .prev_ins   ((i == 0) ? 1'b0 : cell_ins[(i == 0) ? 0 : i - 1]),
         .entry      (cell_entry[i]),
         .ins        (cell_ins[i])
      );
   end

   // The walk reads one slot per cycle while the output can advance: the sweep index
   // while sweeping, the playback index otherwise.
   assign rd_sel   = (state_ff == ST_SWEEP) ? idx_ff : next_ff;
   assign rd_entry = cell_entry[rd_sel[IW-1:0]];

   // Playback is over once the index passes the last entry; otherwise the
   // entry under the index fires when its time has been reached.
   assign fire_end = (next_ff >= count_ff);
   assign fire_due = !fire_end && (rd_entry.tm <= elapsed_ff);

   // The held item moves to the output register in these cases.
   always_comb begin
      unique case (state_ff)
         ST_FIRE:  rsp_load = adv && pend_valid_ff && !(fire_end && close_ff);
         ST_SWEEP: rsp_load = adv && pend_valid_ff;
         ST_FLUSH: rsp_load = adv;
         default:  rsp_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         next_ff       <= '0;
         idx_ff        <= '0;
         running_ff    <= 1'b0;
         close_ff      <= 1'b0;
         elapsed_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  pend_ff.e <= '0;
                  unique case (req_type)
                     REQ_ADD: begin
                        pend_valid_ff <= 1'b1;
                        state_ff      <= ST_FLUSH;
                        if (count_ff < DEPTH_C) begin
                           count_ff     <= count_ff + CW'(1);
                           pend_ff.kind <= KIND_ADDED;
                        end else begin
                           pend_ff.kind <= KIND_FULL;
                        end
                     end
                     REQ_CLEAR: begin
                        count_ff      <= '0;
                        pend_ff.kind  <= KIND_CLEARED;
                        pend_valid_ff <= 1'b1;
                        state_ff      <= ST_FLUSH;
                     end
                     REQ_START: begin
                        if (count_ff == '0) begin
                           running_ff    <= 1'b0;
                           close_ff      <= 1'b0;
                           pend_ff.kind  <= KIND_EMPTY;
                           pend_valid_ff <= 1'b1;
                           state_ff      <= ST_FLUSH;
                        end else begin
                           running_ff <= 1'b1;
                           close_ff   <= req_close_when_done;
                           elapsed_ff <= '0;
                           next_ff    <= '0;
                           state_ff   <= ST_FIRE;
                        end
                     end
                     REQ_ABORT: begin
                        running_ff <= 1'b0;
                        close_ff   <= 1'b0;
                        if (count_ff == '0) begin
                           pend_ff.kind  <= KIND_ABORTED;
                           pend_valid_ff <= 1'b1;
                           state_ff      <= ST_FLUSH;
                        end else begin
                           idx_ff   <= '0;
                           state_ff <= ST_SWEEP;
                        end
                     end
                     REQ_TICK: begin
                        if (running_ff) begin
                           if (elapsed_ff != ELAPSED_MAX) begin
                              elapsed_ff <= elapsed_ff + 16'sd1;
                           end
                           state_ff <= ST_FIRE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_FIRE: begin
               if (adv) begin
                  // A held item goes out only once it is known whether more follow.
                  if (fire_due) begin
                     if (pend_valid_ff) begin
                        rsp_ff      <= pend_ff;
                        rsp_last_ff <= 1'b0;
                     end
                     pend_ff       <= '{kind: KIND_FIRE, e: rd_entry};
                     pend_valid_ff <= 1'b1;
                     next_ff       <= next_ff + CW'(1);
                  end else if (fire_end) begin
                     running_ff <= 1'b0;
                     close_ff   <= 1'b0;
                     if (close_ff) begin
                        idx_ff   <= '0;
                        state_ff <= ST_SWEEP;
                     end else begin
                        if (pend_valid_ff) begin
                           rsp_ff      <= pend_ff;
                           rsp_last_ff <= 1'b0;
                        end
                        pend_ff       <= '{kind: KIND_DONE, e: '0};
                        pend_valid_ff <= 1'b1;
                        state_ff      <= ST_FLUSH;
                     end
                  end else begin
                     if (pend_valid_ff) begin
                        rsp_ff      <= pend_ff;
                        rsp_last_ff <= 1'b1;
                     end
                     pend_valid_ff <= 1'b0;
                     state_ff      <= ST_IDLE;
                  end
               end
            end
            ST_SWEEP: begin
               if (adv) begin
                  if (pend_valid_ff) begin
                     rsp_ff      <= pend_ff;
                     rsp_last_ff <= 1'b0;
                  end
                  pend_valid_ff <= 1'b1;
                  if (idx_ff < count_ff) begin
                     pend_ff <= '{kind: KIND_FINISH, e: rd_entry};
                     idx_ff  <= idx_ff + CW'(1);
                  end else begin
                     pend_ff  <= '{kind: KIND_DONE, e: '0};
                     state_ff <= ST_FLUSH;
                  end
               end
            end
            ST_FLUSH: begin
               if (adv) begin
                  rsp_ff        <= pend_ff;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_ff.kind;
   assign rsp_out_device    = rsp_ff.e.dev;
   assign rsp_out_item_id   = rsp_ff.e.ident;
   assign rsp_out_operation = rsp_ff.e.op;
   assign rsp_out_value     = rsp_ff.e.val;
   assign rsp_out_time      = rsp_ff.e.tm;
   assign rsp_last          = rsp_last_ff;
endmodule
`default_nettype wire

### dv/timed_action_sequencer_core_tb.sv
// Testbench of the timed action sequencer: directed and random requests against a predictor.
`timescale 1ns / 1ps
module timed_action_sequencer_core_tb;
   import tas_pkg::*;

   localparam int DEPTH = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [2:0] REQ_SPARE_LO = 3'd5;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = REQ_TICK;
   logic [7:0] req_device_code = '0;
   logic [7:0] req_item_id = '0;
   logic [7:0] req_operation_code = '0;
   logic signed [15:0] req_action_value = '0;
   logic signed [15:0] req_fire_time = '0;
   logic req_close_when_done = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_result_kind;
   logic [7:0] rsp_out_device;
   logic [7:0] rsp_out_item_id;
   logic [7:0] rsp_out_operation;
   logic signed [15:0] rsp_out_value;
   logic signed [15:0] rsp_out_time;
   logic rsp_last;

   timed_action_sequencer_core #(.TABLE_DEPTH(DEPTH)) dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One expected result: the kind, the emitted entry and the last flag.
   typedef struct {
      logic [2:0] kind;
      entry_type  e;
      logic       last;
   } outcome_type;

   outcome_type pending_results[$];

   // Shadow state of the sequencer.
   entry_type schedule[DEPTH];
   int        sched_count;
   bit        playing;
   bit        sweep_on_end;
   logic signed [15:0] clock_ms;
   int        cursor;

   int mismatches;
   int results_seen;
   int items_sent;
   int idle_cycles;
   int hold_requests = 0;   // long receiver stalls asked for by a test
   int hold_served = 0;     // long receiver stalls already carried out

   function automatic void push_result(logic [2:0] kind, entry_type e);
      outcome_type o;
      o.kind = kind;
      o.e = e;
      o.last = 1'b0;
      pending_results.push_back(o);
   endfunction

   function automatic void sweep_schedule();
      for (int i = 0; i < sched_count; i++) push_result(KIND_FINISH, schedule[i]);
      push_result(KIND_DONE, '0);
   endfunction

   // Fires every due entry; once the cursor passes the end, playback stops.
   function automatic void fire_due_entries();
      while (cursor < sched_count && schedule[cursor].tm <= clock_ms) begin
         push_result(KIND_FIRE, schedule[cursor]);
         cursor++;
      end
      if (cursor >= sched_count) begin
         playing = 1'b0;
         if (sweep_on_end) sweep_schedule();
         else push_result(KIND_DONE, '0);
         sweep_on_end = 1'b0;
      end
   endfunction

   function automatic void predict_request(logic [2:0] kind, entry_type e, bit close);
      int before_n;
      int pos;
      before_n = pending_results.size();
      case (kind)
         REQ_ADD: begin
            if (sched_count >= DEPTH) begin
               push_result(KIND_FULL, '0);
            end else begin
               pos = sched_count;
               for (int i = 0; i < sched_count; i++)
                  if (e.tm < schedule[i].tm) begin
                     pos = i;
                     break;
                  end
               for (int i = sched_count; i > pos; i--) schedule[i] = schedule[i - 1];
               schedule[pos] = e;
               sched_count++;
               push_result(KIND_ADDED, '0);
            end
         end
         REQ_CLEAR: begin
            sched_count = 0;
            push_result(KIND_CLEARED, '0);
         end
         REQ_START: begin
            if (sched_count == 0) begin
               playing = 1'b0;
               sweep_on_end = 1'b0;
               push_result(KIND_EMPTY, '0);
            end else begin
               playing = 1'b1;
               sweep_on_end = close;
               clock_ms = '0;
               cursor = 0;
               fire_due_entries();
            end
         end
         REQ_ABORT: begin
            playing = 1'b0;
            sweep_on_end = 1'b0;
            if (sched_count == 0) push_result(KIND_ABORTED, '0);
            else sweep_schedule();
         end
         REQ_TICK: begin
            if (playing) begin
               if (clock_ms < ELAPSED_MAX) clock_ms++;
               fire_due_entries();
            end
         end
         default: ;
      endcase
      if (pending_results.size() > before_n)
         pending_results[pending_results.size() - 1].last = 1'b1;
   endfunction

   // Drives one request at the falling edge and holds it until it is taken.
   task automatic send_request(logic [2:0] kind, entry_type e = '0, bit close = 1'b0,
                               bit no_gap = 1'b0);
      int gap;
      if (!no_gap) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
               ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = kind;
      req_device_code = e.dev;
      req_item_id = e.ident;
      req_operation_code = e.op;
      req_action_value = e.val;
      req_fire_time = e.tm;
      req_close_when_done = close;
      do @(posedge clock); while (!req_ready);
      predict_request(kind, e, close);
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic entry_type random_entry(int tmin, int tmax);
      entry_type e;
      e.dev = 8'($urandom);
      e.ident = 8'($urandom);
      e.op = 8'($urandom);
      e.val = 16'($urandom);
      e.tm = 16'(int'($urandom_range(0, tmax - tmin)) + tmin);
      return e;
   endfunction

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Receiver: random stalls, plus a long hold-off of its own count when a test asks.
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         if (hold_requests != hold_served) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_served++;
         end else begin
            stall = ($urandom_range(0, 14) == 0) ? $urandom_range(8, 30) :
                    ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d last %0b", rsp_result_kind, rsp_last);
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind || rsp_out_device !== want.e.dev ||
                rsp_out_item_id !== want.e.ident || rsp_out_operation !== want.e.op ||
                rsp_out_value !== want.e.val || rsp_out_time !== want.e.tm ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected k%0d d%0h i%0h o%0h v%0d t%0d l%0b,",
                           want.kind, want.e.dev, want.e.ident, want.e.op, want.e.val,
                           want.e.tm, want.last,
                           " got k%0d d%0h i%0h o%0h v%0d t%0d l%0b",
                           rsp_result_kind, rsp_out_device, rsp_out_item_id,
                           rsp_out_operation, rsp_out_value, rsp_out_time, rsp_last);
            end
         end
      end
   end

   // Watchdog: cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("** timed_action_sequencer_core: FAILED **");
         $finish;
      end
   end

   task automatic test_directed();
      entry_type e;
      // Idle corner cases: abort, tick, start and unused request codes on an empty table.
      send_request(REQ_ABORT);
      send_request(REQ_TICK);
      send_request(REQ_START, '0, 1'b1);
      send_request(REQ_SPARE_LO);
      send_request(REQ_SPARE_HI);
      // Field extremes and equal-time ordering.
      e = '{dev: 8'hFF, ident: 8'h00, op: 8'hFF, val: 16'sh7FFF, tm: 16'sh8000};
      send_request(REQ_ADD, e);
      e = '{dev: 8'h00, ident: 8'hFF, op: 8'h00, val: 16'sh8000, tm: 16'sh7FFF};
      send_request(REQ_ADD, e);
      e = '{dev: 8'h5A, ident: 8'hA5, op: 8'h3C, val: 16'sh1234, tm: 16'sd2};
      send_request(REQ_ADD, e);
      e.dev = 8'hC3;
      send_request(REQ_ADD, e);
      e = '{dev: 8'h11, ident: 8'h22, op: 8'h33, val: -16'sd1, tm: 16'sd0};
      send_request(REQ_ADD, e);
      // Start fires the entries due at or before zero, then ticks fire those due by two.
      send_request(REQ_START, '0, 1'b1);
      send_request(REQ_TICK);
      send_request(REQ_TICK);
      // Add during playback, then restart, then abort with a full sweep.
      send_request(REQ_ADD, random_entry(3, 5));
      send_request(REQ_START, '0, 1'b0);
      send_request(REQ_TICK);
      send_request(REQ_ABORT);
      // Clear during playback ends it on the next tick.
      send_request(REQ_START, '0, 1'b1);
      send_request(REQ_CLEAR);
      send_request(REQ_TICK);
      // All entries due at start: playback ends within the start.
      send_request(REQ_ADD, random_entry(-5, 0));
      send_request(REQ_START, '0, 1'b0);
      send_request(REQ_CLEAR);
      wait_drained();
   endtask

   // Fills the table past capacity while the receiver stalls for long.
   task automatic test_full_and_backpressure();
      hold_requests++;
      for (int i = 0; i < DEPTH + 2; i++) send_request(REQ_ADD, random_entry(-3, 6), 1'b0, 1'b1);
      send_request(REQ_ABORT, '0, 1'b0, 1'b1);
      wait_drained();
      send_request(REQ_START, '0, 1'b1);
      for (int i = 0; i < 8; i++) send_request(REQ_TICK);
      wait_drained();
   endtask

   // Random sessions: build a schedule, play it with ticks, with some noise.
   task automatic test_random_sessions();
      int n;
      logic [2:0] noise;
      while (items_sent < 250) begin
         send_request(REQ_CLEAR);
         n = $urandom_range(0, 4) == 0 ? $urandom_range(14, 18) : $urandom_range(1, 8);
         for (int i = 0; i < n; i++) send_request(REQ_ADD, random_entry(-4, 12));
         send_request(REQ_START, '0, 1'($urandom_range(0, 1)));
         for (int t = 0; t < $urandom_range(4, 16); t++) begin
            if ($urandom_range(0, 11) == 0) begin
               noise = 3'($urandom_range(0, 7));
               send_request(noise, random_entry(-4, 12), 1'($urandom_range(0, 1)));
            end else begin
               send_request(REQ_TICK);
            end
         end
         if ($urandom_range(0, 3) == 0) send_request(REQ_ABORT);
      end
      wait_drained();
   endtask

   initial begin
      sched_count = 0;
      playing = 1'b0;
      sweep_on_end = 1'b0;
      clock_ms = '0;
      cursor = 0;
      mismatches = 0;
      results_seen = 0;
      items_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_and_backpressure();
      test_random_sessions();
      $display("Covered %0d requests and %0d results: idle commands, full table,", items_sent,
               results_seen);
      $display("playback with sweeps, restart, clear and abort, and a long result stall.");
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("** timed_action_sequencer_core: PASSED **");
      end else begin
         $display("** timed_action_sequencer_core: FAILED **");
      end
      $finish;
   end
endmodule

### filelist.f
rtl/core/tas_pkg.sv
rtl/core/tas_cell.sv
rtl/core/timed_action_sequencer_core.sv
dv/timed_action_sequencer_core_tb.sv
